// ----- rtl/sle_pkg.sv -----
// Package: shared types, constants and command codes for the serial line editor.
`timescale 1ns / 1ps
package sle_pkg;

    // Default sizes
    localparam int BUF_DEPTH_DEF   = 32;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Terminal byte codes
    localparam logic [7:0] CH_BS       = 8'h08;
    localparam logic [7:0] CH_DEL      = 8'h7f;
    localparam logic [7:0] CH_ESC      = 8'h1b;
    localparam logic [7:0] CH_LBRACKET = 8'h5b;
    localparam logic [7:0] CH_D        = 8'h44;
    localparam logic [7:0] CH_C        = 8'h43;
    localparam logic [7:0] CH_CR       = 8'h0d;
    localparam logic [7:0] CH_LF       = 8'h0a;

    // Result kinds
    localparam logic KIND_ECHO = 1'b0;
    localparam logic KIND_CMD  = 1'b1;

    // Classified operations handed from front to back
    typedef enum logic [2:0] {
        OP_CHAR,
        OP_BS,
        OP_ESC,
        OP_NL,
        OP_LEFT,
        OP_RIGHT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
    } cmd_t;

    // Escape sequence tracking in the front
    typedef enum logic [1:0] {
        ESC_IDLE,
        ESC_OPEN,
        ESC_DIR
    } esc_state_t;

    // Back sequencer
    typedef enum logic [3:0] {
        B_IDLE,
        B_ECHO,
        B_LF,
        B_CMD_RD,
        B_CMD_OUT,
        B_INS,
        B_INS_PUT,
        B_DEL,
        B_LEFT,
        B_RIGHT_ESC,
        B_RIGHT_BRK,
        B_RIGHT_C
    } back_state_t;

endpackage

// ----- rtl/sle_front.sv -----
// Front end: accepts received bytes, tracks escape sequences, classifies into operations.
`timescale 1ns / 1ps
module sle_front
    import sle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] rx_byte
    input  logic       q_full,
    output logic       q_push,
    output cmd_t       q_cmd
);

    esc_state_t state_reg, state_next;
    logic       bracket_reg, bracket_next;
    logic       accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    // Escape phase next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ESC_IDLE:
            begin
                if (accept && s_tdata == CH_ESC)
                begin
                    state_next = ESC_OPEN;
                end
            end
            ESC_OPEN:
            begin
                if (accept)
                begin
                    state_next = ESC_DIR;
                end
            end
            ESC_DIR:
            begin
                if (accept)
                begin
                    state_next = ESC_IDLE;
                end
            end
            default:
            begin
                state_next = ESC_IDLE;
            end
        endcase
    end

    // Classification and queue push
    always_comb
    begin
        q_push       = 1'b0;
        q_cmd.op     = OP_CHAR;
        q_cmd.data   = s_tdata;
        bracket_next = bracket_reg;
        case (state_reg)
            ESC_IDLE:
            begin
                if (accept)
                begin
                    q_push = 1'b1;
                    if (s_tdata inside {CH_CR, CH_LF})
                    begin
                        q_cmd.op = OP_NL;
                    end
                    else if (s_tdata inside {CH_BS, CH_DEL})
                    begin
                        q_cmd.op = OP_BS;
                    end
                    else if (s_tdata == CH_ESC)
                    begin
                        q_cmd.op     = OP_ESC;
                        bracket_next = 1'b0;
                    end
                end
            end
            ESC_OPEN:
            begin
                if (accept)
                begin
                    bracket_next = (s_tdata == CH_LBRACKET);
                end
            end
            ESC_DIR:
            begin
                if (accept)
                begin
                    bracket_next = 1'b0;
                    if (bracket_reg && s_tdata == CH_D)
                    begin
                        q_push   = 1'b1;
                        q_cmd.op = OP_LEFT;
                    end
                    else if (bracket_reg && s_tdata == CH_C)
                    begin
                        q_push   = 1'b1;
                        q_cmd.op = OP_RIGHT;
                    end
                end
            end
            default:
            begin
                bracket_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ESC_IDLE;
            bracket_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            bracket_reg <= bracket_next;
        end
    end

endmodule

// ----- rtl/sle_queue.sv -----
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
module sle_queue
    import sle_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic valid,
    output cmd_t head_cmd
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

    cmd_t          slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign valid    = (count_reg != '0);
    assign head_cmd = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage slots
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Fill count never passes the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");

endmodule

// ----- rtl/sle_back.sv -----
// Back end: line memory, cursor and length, and result sequencing.
`timescale 1ns / 1ps
module sle_back
    import sle_pkg::*;
#(
    parameter int BUF_DEPTH = BUF_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  cmd_t       q_cmd,
    output logic       q_pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] out_byte
    output logic [1:0] m_tuser,    // [0] out_kind, [1] command_end
    output logic       m_tlast     // last result of the request
);

    localparam int AW = $clog2(BUF_DEPTH);
    localparam logic [AW-1:0] LEN_MAX = AW'(BUF_DEPTH - 1);

    back_state_t   state_reg, state_next;
    op_t           op_reg, op_next;
    logic [7:0]    byte_reg, byte_next;
    logic [AW-1:0] len_reg, len_next;
    logic [AW-1:0] cursor_reg, cursor_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW:0]   idx_inc;
    logic          cmd_final;

    // Line memory and its pipelined move write-back
    logic [7:0]    mem [BUF_DEPTH];
    logic [7:0]    rd_data_reg;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wb_valid_reg, wb_valid_next;
    logic [AW-1:0] wb_addr_reg, wb_addr_next;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          put;

    // Output register
    logic          out_valid_reg, out_valid_next;
    logic          out_kind_reg;
    logic [7:0]    out_byte_reg;
    logic          out_end_reg;
    logic          out_last_reg;
    logic          slot_free;
    logic          emit;
    logic          emit_kind;
    logic [7:0]    emit_byte;
    logic          emit_end;
    logic          emit_last;

    assign slot_free = !out_valid_reg || m_tready;
    assign idx_inc   = {1'b0, idx_reg} + (AW + 1)'(1);
    assign cmd_final = (idx_inc == {1'b0, len_reg});

    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_byte_reg;
    assign m_tuser   = {out_end_reg, out_kind_reg};
    assign m_tlast   = out_last_reg;

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_cmd.op)
                        OP_LEFT:  state_next = (cursor_reg != '0) ? B_LEFT : B_IDLE;
                        OP_RIGHT: state_next = (cursor_reg < len_reg) ? B_RIGHT_ESC : B_IDLE;
                        default:  state_next = B_ECHO;
                    endcase
                end
            end
            B_ECHO:
            begin
                if (slot_free)
                begin
                    case (op_reg)
                        OP_NL:   state_next = B_LF;
                        OP_CHAR: state_next = (len_reg < LEN_MAX) ? B_INS : B_IDLE;
                        OP_BS:   state_next = (cursor_reg != '0) ? B_DEL : B_IDLE;
                        default: state_next = B_IDLE;
                    endcase
                end
            end
            B_LF:
            begin
                if (slot_free)
                begin
                    state_next = (len_reg == '0) ? B_IDLE : B_CMD_RD;
                end
            end
            B_CMD_RD:
            begin
                state_next = B_CMD_OUT;
            end
            B_CMD_OUT:
            begin
                if (slot_free && cmd_final)
                begin
                    state_next = B_IDLE;
                end
            end
            B_INS:
            begin
                if (idx_reg == cursor_reg)
                begin
                    state_next = B_INS_PUT;
                end
            end
            B_INS_PUT:
            begin
                state_next = B_IDLE;
            end
            B_DEL:
            begin
                if (idx_inc >= {1'b0, len_reg})
                begin
                    state_next = B_IDLE;
                end
            end
            B_LEFT:
            begin
                if (slot_free)
                begin
                    state_next = B_IDLE;
                end
            end
            B_RIGHT_ESC:
            begin
                if (slot_free)
                begin
                    state_next = B_RIGHT_BRK;
                end
            end
            B_RIGHT_BRK:
            begin
                if (slot_free)
                begin
                    state_next = B_RIGHT_C;
                end
            end
            B_RIGHT_C:
            begin
                if (slot_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Sequencer outputs, buffer moves and emitted results
    always_comb
    begin
        q_pop         = 1'b0;
        op_next       = op_reg;
        byte_next     = byte_reg;
        len_next      = len_reg;
        cursor_next   = cursor_reg;
        idx_next      = idx_reg;
        rd_en         = 1'b0;
        rd_addr       = idx_reg;
        wb_valid_next = 1'b0;
        wb_addr_next  = wb_addr_reg;
        put           = 1'b0;
        emit          = 1'b0;
        emit_kind     = KIND_ECHO;
        emit_byte     = byte_reg;
        emit_end      = 1'b0;
        emit_last     = 1'b1;
        case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    op_next   = q_cmd.op;
                    byte_next = q_cmd.data;
                end
            end
            B_ECHO:
            begin
                if (slot_free)
                begin
                    emit      = 1'b1;
                    emit_last = (op_reg != OP_NL);
                    idx_next  = (op_reg == OP_BS) ? cursor_reg - AW'(1) : len_reg;
                end
            end
            B_LF:
            begin
                if (slot_free)
                begin
                    emit      = 1'b1;
                    emit_byte = CH_LF;
                    emit_last = (len_reg == '0);
                    idx_next  = '0;
                end
            end
            B_CMD_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = idx_reg;
            end
            B_CMD_OUT:
            begin
                if (slot_free)
                begin
                    emit      = 1'b1;
                    emit_kind = KIND_CMD;
                    emit_byte = rd_data_reg;
                    emit_end  = cmd_final;
                    emit_last = cmd_final;
                    if (cmd_final)
                    begin
                        len_next    = '0;
                        cursor_next = '0;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = idx_inc[AW-1:0];
                        idx_next = idx_inc[AW-1:0];
                    end
                end
            end
            B_INS:
            begin
                // shift one entry up per cycle, from the end down to the cursor
                if (idx_reg != cursor_reg)
                begin
                    rd_en         = 1'b1;
                    rd_addr       = idx_reg - AW'(1);
                    wb_valid_next = 1'b1;
                    wb_addr_next  = idx_reg;
                    idx_next      = idx_reg - AW'(1);
                end
            end
            B_INS_PUT:
            begin
                put         = 1'b1;
                len_next    = len_reg + AW'(1);
                cursor_next = cursor_reg + AW'(1);
            end
            B_DEL:
            begin
                // shift one entry down per cycle, from the cursor to the end
                if (idx_inc < {1'b0, len_reg})
                begin
                    rd_en         = 1'b1;
                    rd_addr       = idx_inc[AW-1:0];
                    wb_valid_next = 1'b1;
                    wb_addr_next  = idx_reg;
                    idx_next      = idx_inc[AW-1:0];
                end
                else
                begin
                    len_next    = len_reg - AW'(1);
                    cursor_next = cursor_reg - AW'(1);
                end
            end
            B_LEFT:
            begin
                if (slot_free)
                begin
                    emit        = 1'b1;
                    emit_byte   = CH_BS;
                    cursor_next = cursor_reg - AW'(1);
                end
            end
            B_RIGHT_ESC:
            begin
                if (slot_free)
                begin
                    emit      = 1'b1;
                    emit_byte = CH_ESC;
                    emit_last = 1'b0;
                end
            end
            B_RIGHT_BRK:
            begin
                if (slot_free)
                begin
                    emit      = 1'b1;
                    emit_byte = CH_LBRACKET;
                    emit_last = 1'b0;
                end
            end
            B_RIGHT_C:
            begin
                if (slot_free)
                begin
                    emit        = 1'b1;
                    emit_byte   = CH_C;
                    cursor_next = cursor_reg + AW'(1);
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // Memory write port: move write-back or the inserted character
    assign wr_en   = wb_valid_reg || put;
    assign wr_addr = put ? cursor_reg : wb_addr_reg;
    assign wr_data = put ? byte_reg : rd_data_reg;

    assign out_valid_next = emit ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            len_reg       <= '0;
            cursor_reg    <= '0;
            wb_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            cursor_reg    <= cursor_next;
            wb_valid_reg  <= wb_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and working registers
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        byte_reg    <= byte_next;
        idx_reg     <= idx_next;
        wb_addr_reg <= wb_addr_next;
        if (emit)
        begin
            out_kind_reg <= emit_kind;
            out_byte_reg <= emit_byte;
            out_end_reg  <= emit_end;
            out_last_reg <= emit_last;
        end
    end

    // Line memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    a_cursor_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= len_reg)
        else $error("cursor past end of line");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_MAX)
        else $error("line length beyond capacity");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_end_reg) |-> (out_last_reg && out_kind_reg == KIND_CMD))
        else $error("command end not on last command result");

    a_wb_from_move: assert property (@(posedge clk) disable iff (!rst_n)
        wb_valid_reg |-> ($past(state_reg) == B_INS || $past(state_reg) == B_DEL))
        else $error("write-back outside a buffer move");

endmodule

// ----- rtl/serial_line_editor.sv -----
// Top level of the serial line editor: front end, command queue and back end.
//
//  channel   dir  tdata             tuser                       tlast
//  s_*       in   [7:0] rx_byte     -                           -
//  m_*       out  [7:0] out_byte    [0] out_kind, [1] cmd_end   last result of request
//
// A request may echo only; an insert or delete also moves the line memory entries
// between the cursor and the end, one entry per cycle, and a line end reads out every
// entry; the line memory has separate read and write ports for these walks.
// Reset clears length, cursor, escape state, queue and output register at once; the
// line memory is not cleared.
// The front keeps taking requests while the queue has room; the back waits on m_tready.
`timescale 1ns / 1ps
module serial_line_editor
    import sle_pkg::*;
#(
    parameter int BUF_DEPTH   = BUF_DEPTH_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] rx_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] out_byte
    output logic [1:0] m_tuser,    // [0] out_kind, [1] command_end
    output logic       m_tlast     // last result of the request
);

    logic q_push;
    cmd_t q_push_cmd;
    logic q_full;
    logic q_pop;
    logic q_valid;
    cmd_t q_head_cmd;

    sle_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_push_cmd)
    );

    sle_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head_cmd (q_head_cmd)
    );

    sle_back #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_cmd    (q_head_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- tb/tb.sv -----
// Testbench for serial_line_editor: request stimulus, line edit predictor and result checks.
`timescale 1ns / 1ps
module tb;
    import sle_pkg::*;

    localparam int LINE_MAX       = BUF_DEPTH_DEF - 1;
    localparam int STALL_LIMIT    = 3000;
    localparam int SETTLE_CYCLES  = 60;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       cmd_end;
        logic       last;
    } term_out_t;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic       m_tlast;

    // Predicted editor state
    logic [7:0] line_chars [BUF_DEPTH_DEF];
    int         line_len;
    int         edit_cursor;
    esc_state_t esc_phase;
    logic       bracket_seen;

    term_out_t  expected_out [$];
    int         mismatch_count;
    int         quiet_cycles;
    int         send_gap_pct;
    int         ready_stall_pct;

    serial_line_editor i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Receiver back-pressure
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= ready_stall_pct);
    end

    // Line editor prediction for one accepted request
    task automatic apply_rx_byte(input logic [7:0] b);
        term_out_t res [$];
        int        k;
        if (esc_phase == ESC_OPEN)
        begin
            bracket_seen = (b == CH_LBRACKET);
            esc_phase    = ESC_DIR;
        end
        else if (esc_phase == ESC_DIR)
        begin
            esc_phase = ESC_IDLE;
            if (bracket_seen)
            begin
                if (b == CH_D && edit_cursor > 0)
                begin
                    res.push_back('{KIND_ECHO, CH_BS, 1'b0, 1'b0});
                    edit_cursor--;
                end
                else if (b == CH_C && edit_cursor < line_len)
                begin
                    res.push_back('{KIND_ECHO, CH_ESC, 1'b0, 1'b0});
                    res.push_back('{KIND_ECHO, CH_LBRACKET, 1'b0, 1'b0});
                    res.push_back('{KIND_ECHO, CH_C, 1'b0, 1'b0});
                    edit_cursor++;
                end
            end
            bracket_seen = 1'b0;
        end
        else
        begin
            res.push_back('{KIND_ECHO, b, 1'b0, 1'b0});
            if (b == CH_CR || b == CH_LF)
            begin
                res.push_back('{KIND_ECHO, CH_LF, 1'b0, 1'b0});
                for (k = 0; k < line_len; k++)
                    res.push_back('{KIND_CMD, line_chars[k], (k == line_len - 1), 1'b0});
                line_len    = 0;
                edit_cursor = 0;
            end
            else if (b == CH_BS || b == CH_DEL)
            begin
                if (edit_cursor > 0)
                begin
                    for (k = edit_cursor - 1; k < line_len - 1; k++)
                        line_chars[k] = line_chars[k + 1];
                    line_len--;
                    edit_cursor--;
                end
            end
            else if (b == CH_ESC)
            begin
                esc_phase    = ESC_OPEN;
                bracket_seen = 1'b0;
            end
            else if (line_len < LINE_MAX)
            begin
                for (k = line_len; k > edit_cursor; k--)
                    line_chars[k] = line_chars[k - 1];
                line_chars[edit_cursor] = b;
                line_len++;
                edit_cursor++;
            end
        end
        if (res.size() > 0)
            res[res.size() - 1].last = 1'b1;
        foreach (res[i])
            expected_out.push_back(res[i]);
    endtask

    // Drive one request and wait for it to be taken
    task automatic send_rx(input logic [7:0] b);
        @(negedge clk);
        while ($urandom_range(99) < send_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        apply_rx_byte(b);
    endtask

    // Hold off new requests until every predicted result has come out
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_out.size() != 0)
            @(posedge clk);
    endtask

    // Random byte that the editor treats as plain text
    function automatic logic [7:0] rand_plain_byte();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        while (b == CH_CR || b == CH_LF || b == CH_BS || b == CH_DEL || b == CH_ESC)
            b = 8'($urandom_range(255));
        return b;
    endfunction

    // Field extremes and each special case of the editor
    task automatic test_directed();
        logic [7:0] seq [] = '{
            CH_CR,                       // line end on an empty line
            CH_BS,                       // delete with cursor at zero
            CH_ESC, CH_LBRACKET, CH_D,   // left with cursor at zero
            8'h00, 8'hff, 8'h61,
            CH_ESC, CH_LBRACKET, CH_D,   // left
            8'h62,                       // insert in the middle
            CH_DEL,                      // delete in the middle
            CH_ESC, CH_LBRACKET, CH_C,   // right
            CH_ESC, CH_LBRACKET, CH_C,   // right at end of line
            CH_ESC, CH_LF, CH_D,         // no bracket, LF inside sequence
            CH_LF,                       // line end with content
            CH_ESC, CH_CR, CH_ESC        // CR and ESC taken inside sequence
        };
        foreach (seq[i])
            send_rx(seq[i]);
    endtask

    // Fill the line, overflow it, edit at the end, then flush it
    task automatic test_full_line();
        repeat (LINE_MAX + 3)
            send_rx(rand_plain_byte());
        send_rx(CH_BS);
        send_rx(rand_plain_byte());
        send_rx(rand_plain_byte());
        send_rx(CH_CR);
        wait_drained();
    endtask

    // Random edit sessions, mostly well-formed sequences
    task automatic test_random_edits(input int n_items);
        int sent;
        int pick;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 52)
            begin
                send_rx(rand_plain_byte());
                sent += 1;
            end
            else if (pick < 62)
            begin
                send_rx($urandom_range(1) ? CH_BS : CH_DEL);
                sent += 1;
            end
            else if (pick < 80)
            begin
                // cursor movement, sometimes malformed
                send_rx(CH_ESC);
                send_rx(($urandom_range(9) < 8) ? CH_LBRACKET : 8'($urandom_range(255)));
                if ($urandom_range(9) < 8)
                    send_rx($urandom_range(1) ? CH_D : CH_C);
                else
                    send_rx(8'($urandom_range(255)));
                sent += 3;
            end
            else if (pick < 87)
            begin
                send_rx($urandom_range(1) ? CH_CR : CH_LF);
                sent += 1;
            end
            else
            begin
                send_rx(8'($urandom_range(255)));
                sent += 1;
            end
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin
        term_out_t got;
        term_out_t want;
        got = '{m_tuser[0], m_tdata, m_tuser[1], m_tlast};
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_out.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected result kind=%0b byte=%02h end=%0b last=%0b",
                             $realtime, got.kind, got.data, got.cmd_end, got.last);
            end
            else
            begin
                want = expected_out.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $display("%0t: mismatch exp kind=%0b byte=%02h end=%0b last=%0b",
                                 $realtime, want.kind, want.data, want.cmd_end, want.last);
                        $display("%0t:          got kind=%0b byte=%02h end=%0b last=%0b",
                                 $realtime, got.kind, got.data, got.cmd_end, got.last);
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Main sequence
    initial
    begin
        rst_n           = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = 8'h00;
        m_tready        = 1'b0;
        line_len        = 0;
        edit_cursor     = 0;
        esc_phase       = ESC_IDLE;
        bracket_seen    = 1'b0;
        mismatch_count  = 0;
        quiet_cycles    = 0;
        send_gap_pct    = 0;
        ready_stall_pct = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_full_line();

        // idling phases: none, sender, receiver, both
        test_random_edits(75);
        send_gap_pct = 63;
        test_random_edits(75);
        wait_drained();
        send_gap_pct    = 0;
        ready_stall_pct = 63;
        test_random_edits(75);
        send_gap_pct    = 23;
        ready_stall_pct = 23;
        test_random_edits(75);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_out.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- serial_line_editor.f -----
rtl/sle_pkg.sv
rtl/sle_front.sv
rtl/sle_queue.sv
rtl/sle_back.sv
rtl/serial_line_editor.sv
tb/tb.sv
